// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define ACFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ACFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ACFE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ACFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/acfe_pkg.sv
package acfe_pkg;

  // Field widths of the two channels.
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 18;
  localparam int FREQ_W  = 18;
  localparam int BYTE_W  = 8;

  // Request codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_RX_BYTE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_FREQ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_DIR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_AUTO  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CALIBRATE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HOME      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_POLL      = 3'd6;

  // Link bytes.
  localparam logic [7:0] SOF_BYTE     = 8'h40;
  localparam logic [7:0] ADDR_BYTE    = 8'h41;
  localparam logic [7:0] MODE_BYTE    = 8'h40;
  localparam logic [7:0] CR_BYTE      = 8'h0d;
  localparam logic [7:0] POLL_BYTE    = 8'h3f;
  localparam logic [7:0] OP_SET_FREQ  = 8'h31;
  localparam logic [7:0] OP_SET_DIR   = 8'h00;
  localparam logic [7:0] OP_AUTO_ON   = 8'h52;
  localparam logic [7:0] OP_AUTO_OFF  = 8'h55;
  localparam logic [7:0] OP_CALIBRATE = 8'h56;
  localparam logic [7:0] OP_HOME      = 8'h53;

  // Frequency limits and scaling.
  localparam logic [FREQ_W-1:0] FREQ_MAX   = 18'd167772;
  localparam logic [6:0]        FREQ_SCALE = 7'd100;

  // enc / 100 == (enc * DIV100_RECIP) >> DIV100_SHIFT for every 24-bit enc.
  localparam logic [24:0] DIV100_RECIP = 25'd21474837;
  localparam int          DIV100_SHIFT = 31;

  // Frame lengths in bytes.
  localparam logic [3:0] FRAME_LEN = 4'd11;
  localparam logic [3:0] POLL_LEN  = 4'd3;

  // Receive buffer: only the first eight bytes of a frame are kept.
  localparam int          RX_DEPTH = 8;
  localparam logic [3:0]  RX_MIN   = 4'd7;
  localparam logic [3:0]  RX_SAT   = 4'd15;

  // Direction codes.
  localparam logic [1:0] DIR_NORMAL = 2'd0;
  localparam logic [1:0] DIR_REV    = 2'd1;
  localparam logic [1:0] DIR_BIDIR  = 2'd2;
  localparam logic [1:0] DIR_3Q     = 2'd3;

  typedef enum logic [1:0] {
    JOB_STATUS,
    JOB_FRAME,
    JOB_POLL
  } job_kind_t;

  // One pending output job: a status report, a command frame or a poll.
  typedef struct packed {
    job_kind_t         kind;
    logic [7:0]        op_byte;
    logic [FREQ_W-1:0] freq;
    logic              tuning;
    logic [1:0]        dir;
    logic              autotrack;
    logic              freq_chg;
    logic              tuning_chg;
    logic              dir_chg;
    logic              auto_chg;
  } job_t;

  // Direction code to the byte sent in a command frame.
  function automatic logic [7:0] dir_to_byte(input logic [1:0] d);
    logic [7:0] b;
    case (d)
      DIR_REV:   b = 8'h40;
      DIR_BIDIR: b = 8'h80;
      DIR_3Q:    b = 8'h20;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  // Top three bits of the status byte to a direction code.
  function automatic logic [1:0] bits_to_dir(input logic [2:0] b);
    logic [1:0] d;
    case (b)
      3'd2:    d = DIR_REV;
      3'd4:    d = DIR_BIDIR;
      3'd3:    d = DIR_3Q;
      default: d = DIR_NORMAL;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/acfe_in_if.sv
interface acfe_in_if;
  import acfe_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

// File: hw/rtl/acfe_out_if.sv
interface acfe_out_if;
  import acfe_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] tx_byte;
  logic              last;
  logic [FREQ_W-1:0] freq_khz;
  logic              tuning_flag;
  logic [1:0]        dir_mode;
  logic              autotrack_on;
  logic              freq_changed;
  logic              tuning_changed;
  logic              dir_changed;
  logic              autotrack_changed;

  modport source (output valid, kind, tx_byte, last, freq_khz, tuning_flag, dir_mode,
                  autotrack_on, freq_changed, tuning_changed, dir_changed,
                  autotrack_changed, input ready);
  modport sink   (input valid, kind, tx_byte, last, freq_khz, tuning_flag, dir_mode,
                  autotrack_on, freq_changed, tuning_changed, dir_changed,
                  autotrack_changed, output ready);
endinterface

// File: hw/rtl/acfe_tx_seq.sv
module acfe_tx_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  acfe_pkg::job_t job_in,
  output logic          free,
  acfe_out_if.source    out_ch
);
  import acfe_pkg::*;

  logic        valid_r;
  job_t        job_r;
  logic [3:0]  idx_r;
  logic        last_beat;
  logic [24:0] enc_full;
  logic [23:0] enc;
  logic [7:0]  frame_byte;
  logic [7:0]  poll_byte;
  logic [7:0]  mode_byte;

  // Final result of the held job.
  always_comb begin
    case (job_r.kind)
      JOB_STATUS: last_beat = 1'b1;
      JOB_POLL:   last_beat = (idx_r == POLL_LEN - 4'd1);
      default:    last_beat = (idx_r == FRAME_LEN - 4'd1);
    endcase
  end

  // The slot can take a new job when empty or when its final result leaves now.
  assign free = !valid_r || (out_ch.ready && last_beat);

  // Frequency in the frame is kHz * 100, 24 bits.
  assign enc_full = 25'(job_r.freq) * 25'(FREQ_SCALE);
  assign enc      = enc_full[23:0];

  assign mode_byte = (job_r.op_byte == OP_SET_FREQ || job_r.op_byte == OP_SET_DIR) ?
                     8'h00 : MODE_BYTE;

  // Command frame byte at the current position.
  always_comb begin
    case (idx_r)
      4'd0:    frame_byte = SOF_BYTE;
      4'd1:    frame_byte = ADDR_BYTE;
      4'd2:    frame_byte = mode_byte;
      4'd3:    frame_byte = enc[23:16];
      4'd4:    frame_byte = enc[15:8];
      4'd5:    frame_byte = enc[7:0];
      4'd7:    frame_byte = dir_to_byte(job_r.dir);
      4'd8:    frame_byte = job_r.op_byte;
      4'd10:   frame_byte = CR_BYTE;
      default: frame_byte = 8'h00;
    endcase
  end

  // Poll byte at the current position.
  always_comb begin
    case (idx_r)
      4'd0:    poll_byte = POLL_BYTE;
      4'd1:    poll_byte = ADDR_BYTE;
      default: poll_byte = CR_BYTE;
    endcase
  end

  // Result fields; status fields are zero in transmit results.
  always_comb begin
    out_ch.valid             = valid_r;
    out_ch.kind              = 1'b0;
    out_ch.tx_byte           = 8'h00;
    out_ch.last              = last_beat;
    out_ch.freq_khz          = '0;
    out_ch.tuning_flag       = 1'b0;
    out_ch.dir_mode          = DIR_NORMAL;
    out_ch.autotrack_on      = 1'b0;
    out_ch.freq_changed      = 1'b0;
    out_ch.tuning_changed    = 1'b0;
    out_ch.dir_changed       = 1'b0;
    out_ch.autotrack_changed = 1'b0;
    case (job_r.kind)
      JOB_STATUS: begin
        out_ch.kind              = 1'b1;
        out_ch.last              = 1'b0;
        out_ch.freq_khz          = job_r.freq;
        out_ch.tuning_flag       = job_r.tuning;
        out_ch.dir_mode          = job_r.dir;
        out_ch.autotrack_on      = job_r.autotrack;
        out_ch.freq_changed      = job_r.freq_chg;
        out_ch.tuning_changed    = job_r.tuning_chg;
        out_ch.dir_changed       = job_r.dir_chg;
        out_ch.autotrack_changed = job_r.auto_chg;
      end
      JOB_POLL: out_ch.tx_byte = poll_byte;
      default:  out_ch.tx_byte = frame_byte;
    endcase
  end

  // Job slot and byte position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 4'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 4'd0;
    end else if (valid_r && out_ch.ready) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_in;
    end
  end

endmodule

// File: hw/rtl/antenna_controller_frame_engine.sv
// Antenna-controller link engine. Received link bytes (cmd 0) are gathered up to a carriage
// return; a frame of eight or more bytes that opens with 0x40 is decoded into frequency,
// tuning, direction and autotrack, stored, and reported as one status result with a changed
// flag per value. Command requests give an 11-byte frame and a poll gives 3 bytes, one
// result per cycle on the output channel while it is ready. An item that gives at most one
// result is taken every cycle while the single output job slot is free; a poll or a command
// request holds the input until the slot, which sends one byte a cycle while the output is
// ready, has sent its last byte. The decoded frequency comes from a registered reciprocal
// multiply on bytes 3..5 of the receive buffer, ready before that frame's earliest possible CR.
module antenna_controller_frame_engine (
  input  logic       clk,
  input  logic       rst_n,
  acfe_in_if.sink    in_ch,
  acfe_out_if.source out_ch
);
  import acfe_pkg::*;

`include "assert_macros.svh"

  logic [3:0]        rx_count_r, rx_count_nxt;
  logic [7:0]        rx_bytes_r [RX_DEPTH];
  logic [FREQ_W-1:0] stored_freq_r, stored_freq_nxt;
  logic              stored_tuning_r, stored_tuning_nxt;
  logic [1:0]        stored_dir_r, stored_dir_nxt;
  logic              stored_auto_r, stored_auto_nxt;
  logic [FREQ_W-1:0] quot_r;

  logic              accept;
  logic              slot_free;
  logic              job_load;
  job_t              job_nxt;
  logic [7:0]        byte_in;
  logic              rx_wr;
  logic [23:0]       enc;
  logic [48:0]       div_prod;
  logic [7:0]        stat_byte;
  logic              dec_tuning;
  logic [1:0]        dec_dir;
  logic              dec_auto;
  logic [FREQ_W-1:0] freq_sat;
  logic [1:0]        dir_req;
  logic              cr_taken;
  logic              status_clean;

  assign in_ch.ready = slot_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign byte_in     = in_ch.value[7:0];
  assign rx_wr       = accept && (in_ch.cmd == CMD_RX_BYTE) && !rx_count_r[3];

  // Divide the buffered 24-bit frequency by 100 with a reciprocal multiply.
  assign enc      = {rx_bytes_r[3], rx_bytes_r[4], rx_bytes_r[5]};
  assign div_prod = 49'(enc) * 49'(DIV100_RECIP);

  always_ff @(posedge clk) begin
    quot_r <= div_prod[DIV100_SHIFT +: FREQ_W];
  end

  // Status byte; it is the incoming byte itself when the frame is exactly eight long.
  assign stat_byte  = (rx_count_r == RX_MIN) ? byte_in : rx_bytes_r[7];
  assign dec_tuning = (rx_bytes_r[6] != 8'h00);
  assign dec_dir    = bits_to_dir(stat_byte[7:5]);
  assign dec_auto   = stat_byte[2];

  assign freq_sat = (in_ch.value > FREQ_MAX) ? FREQ_MAX : in_ch.value;
  assign dir_req  = (in_ch.value > VALUE_W'(DIR_3Q)) ? DIR_NORMAL : in_ch.value[1:0];

  // Per-item state update and job build.
  always_comb begin
    rx_count_nxt      = rx_count_r;
    stored_freq_nxt   = stored_freq_r;
    stored_tuning_nxt = stored_tuning_r;
    stored_dir_nxt    = stored_dir_r;
    stored_auto_nxt   = stored_auto_r;
    job_load          = 1'b0;
    job_nxt           = '0;
    job_nxt.kind      = JOB_FRAME;
    job_nxt.freq      = stored_freq_r;
    job_nxt.dir       = stored_dir_r;
    if (accept) begin
      case (in_ch.cmd)
        CMD_RX_BYTE: begin
          if (rx_count_r != RX_SAT) begin
            rx_count_nxt = rx_count_r + 4'd1;
          end
          if (byte_in == CR_BYTE) begin
            rx_count_nxt = 4'd0;
            if (rx_count_r >= RX_MIN && rx_bytes_r[0] == SOF_BYTE) begin
              job_load           = 1'b1;
              job_nxt.kind       = JOB_STATUS;
              job_nxt.freq       = quot_r;
              job_nxt.tuning     = dec_tuning;
              job_nxt.dir        = dec_dir;
              job_nxt.autotrack  = dec_auto;
              job_nxt.freq_chg   = (quot_r != stored_freq_r);
              job_nxt.tuning_chg = (dec_tuning != stored_tuning_r);
              job_nxt.dir_chg    = (dec_dir != stored_dir_r);
              job_nxt.auto_chg   = (dec_auto != stored_auto_r);
              stored_freq_nxt    = quot_r;
              stored_tuning_nxt  = dec_tuning;
              stored_dir_nxt     = dec_dir;
              stored_auto_nxt    = dec_auto;
            end
          end
        end
        CMD_SET_FREQ: begin
          if (in_ch.value != '0) begin
            job_load        = 1'b1;
            job_nxt.op_byte = OP_SET_FREQ;
            job_nxt.freq    = freq_sat;
            stored_freq_nxt = freq_sat;
          end
        end
        CMD_SET_DIR: begin
          job_load        = 1'b1;
          job_nxt.op_byte = OP_SET_DIR;
          job_nxt.dir     = dir_req;
          stored_dir_nxt  = dir_req;
        end
        CMD_SET_AUTO: begin
          job_load        = 1'b1;
          job_nxt.op_byte = in_ch.value[0] ? OP_AUTO_ON : OP_AUTO_OFF;
          stored_auto_nxt = in_ch.value[0];
        end
        CMD_CALIBRATE: begin
          job_load        = 1'b1;
          job_nxt.op_byte = OP_CALIBRATE;
        end
        CMD_HOME: begin
          job_load        = 1'b1;
          job_nxt.op_byte = OP_HOME;
        end
        CMD_POLL: begin
          job_load     = 1'b1;
          job_nxt.kind = JOB_POLL;
        end
        default: begin
          job_load = 1'b0;
        end
      endcase
    end
  end

  // Control and stored link state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r      <= 4'd0;
      stored_freq_r   <= '0;
      stored_tuning_r <= 1'b0;
      stored_dir_r    <= DIR_NORMAL;
      stored_auto_r   <= 1'b0;
    end else begin
      rx_count_r      <= rx_count_nxt;
      stored_freq_r   <= stored_freq_nxt;
      stored_tuning_r <= stored_tuning_nxt;
      stored_dir_r    <= stored_dir_nxt;
      stored_auto_r   <= stored_auto_nxt;
    end
  end

  // Receive buffer keeps the first eight bytes of a frame.
  always_ff @(posedge clk) begin
    if (rx_wr) begin
      rx_bytes_r[rx_count_r[2:0]] <= byte_in;
    end
  end

  acfe_tx_seq u_tx_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (job_load),
    .job_in (job_nxt),
    .free   (slot_free),
    .out_ch (out_ch)
  );

  // Terms checked by the assertions below.
  assign cr_taken     = accept && (in_ch.cmd == CMD_RX_BYTE) && (byte_in == CR_BYTE);
  assign status_clean = (out_ch.tx_byte == 8'h00) && (out_ch.last == 1'b0);

  // A carriage return always restarts gathering.
  `ACFE_ASSERT_NEXT(a_cr_restart, clk, rst_n, cr_taken, rx_count_r == 4'd0)

  // A status result carries no transmit byte and has last low.
  `ACFE_ASSERT_NOW(a_status_clean, clk, rst_n, out_ch.valid && out_ch.kind, status_clean)

  // The stored frequency never leaves its range.
  `ACFE_ASSERT_NOW(a_freq_range, clk, rst_n, 1'b1, stored_freq_r <= FREQ_MAX)

  // No item is taken while a result waits on the output, final or not.
  `ACFE_ASSERT_NOW(a_no_overrun, clk, rst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)

endmodule
